/* hw/rtl/vrp_pkg.sv */
// Shared types, constants and helpers for the vertex rotate/project pipeline.
package vrp_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int ANGLE_BITS    = 14;
  localparam int SCALE_BITS    = 12;
  localparam int SIZE_W        = 13;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 16;

  // Register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COS_Z  = 3'd0,
    CFG_SIN_Z  = 3'd1,
    CFG_COS_X  = 3'd2,
    CFG_SIN_X  = 3'd3,
    CFG_SCL_X  = 3'd4,
    CFG_SCL_Y  = 3'd5,
    CFG_SCR_W  = 3'd6,
    CFG_SCR_H  = 3'd7
  } cfg_idx_t;

  localparam logic [15:0]       RST_COS_Z = 16'd16384;
  localparam logic [15:0]       RST_SIN_Z = 16'd0;
  localparam logic [15:0]       RST_COS_X = 16'd16384;
  localparam logic [15:0]       RST_SIN_X = 16'd0;
  localparam logic [15:0]       RST_SCL_X = 16'd4730;
  localparam logic [15:0]       RST_SCL_Y = 16'd7094;
  localparam logic [SIZE_W-1:0] RST_SCR_W = 13'd720;
  localparam logic [SIZE_W-1:0] RST_SCR_H = 13'd480;

  // Operands handed from the transform front end to the divider
  typedef struct packed {
    logic [31:0] mag_x;
    logic [31:0] mag_y;
    logic [31:0] dmag;
    logic        neg_x;
    logic        neg_y;
    logic [31:0] raw_x;
    logic [31:0] raw_y;
    logic        flat;
  } div_in_t;

  // Side data that travels along the divider stages
  typedef struct packed {
    logic [31:0] dmag;
    logic        neg_x;
    logic        neg_y;
    logic [31:0] raw_x;
    logic [31:0] raw_y;
    logic        flat;
  } div_meta_t;

  // Divider results handed to the screen mapping
  typedef struct packed {
    logic [31:0] q_x;
    logic [31:0] q_y;
    logic        neg_x;
    logic        neg_y;
    logic [31:0] raw_x;
    logic [31:0] raw_y;
    logic        flat;
  } div_out_t;

  // One restoring divide step: returns {quotient bit, new remainder}
  function automatic logic [32:0] div_step(input logic [31:0] rem, input logic nbit,
                                           input logic [31:0] d);
    logic [32:0] cand;
    logic [32:0] diff;
    cand = {rem, nbit};
    diff = cand - {1'b0, d};
    if (cand >= {1'b0, d}) begin
      div_step = {1'b1, diff[31:0]};
    end else begin
      div_step = {1'b0, cand[31:0]};
    end
  endfunction

endpackage

/* hw/rtl/vertex_rotate_project_to_screen_unit.sv */
// Top level of the vertex rotate/project unit: config registers and pipeline.
//
// Usage: one vertex beat enters on the in_ stream (x, y, z signed fixed point
// with FRAC_BITS fraction bits) and one screen position beat leaves on the
// out_ stream (screen_x, screen_y in tdata, depth_zero in tuser). The vertex
// is rotated about Z then X, offset by 3.0 in depth, scaled, divided by depth
// and mapped to pixels. When the offset depth is zero the divide is bypassed
// and depth_zero is set.
// Throughput: one vertex per cycle while the pipeline advances. Stages:
// 7 transform stages, one divider stage per numerator bit (32 + FRAC_BITS),
// and 4 screen mapping stages including the output register.
// The whole pipeline advances together whenever the output register is empty
// or being drained; when the receiver holds out_tready low, all stages hold
// and in_tready drops, so no beat is lost or repeated.
// Reset (rst_n low, synchronous) empties the pipeline and loads the default
// rotation, projection and screen size registers. Write configuration via
// cfg_we/cfg_addr/cfg_wdata only while no vertex is in flight.
module vertex_rotate_project_to_screen_unit #(
  parameter int FRAC_BITS = vrp_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [95:0]                    in_tdata,   // vertex_x, vertex_y, vertex_z
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [63:0]                    out_tdata,  // screen_x, screen_y
  output logic [0:0]                     out_tuser,  // depth_zero
  input  logic                           cfg_we,
  input  logic [vrp_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [vrp_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import vrp_pkg::*;

  logic [15:0]       cos_z_r, sin_z_r, cos_x_r, sin_x_r, scl_x_r, scl_y_r;
  logic [SIZE_W-1:0] scr_w_r, scr_h_r;
  logic              en;
  logic              fr_valid, dv_valid;
  div_in_t           fr_data;
  div_out_t          dv_data;
  logic [31:0]       screen_x, screen_y;
  logic              depth_zero;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cos_z_r <= RST_COS_Z;
      sin_z_r <= RST_SIN_Z;
      cos_x_r <= RST_COS_X;
      sin_x_r <= RST_SIN_X;
      scl_x_r <= RST_SCL_X;
      scl_y_r <= RST_SCL_Y;
      scr_w_r <= RST_SCR_W;
      scr_h_r <= RST_SCR_H;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_addr))
        CFG_COS_Z: cos_z_r <= cfg_wdata;
        CFG_SIN_Z: sin_z_r <= cfg_wdata;
        CFG_COS_X: cos_x_r <= cfg_wdata;
        CFG_SIN_X: sin_x_r <= cfg_wdata;
        CFG_SCL_X: scl_x_r <= cfg_wdata;
        CFG_SCL_Y: scl_y_r <= cfg_wdata;
        CFG_SCR_W: scr_w_r <= cfg_wdata[SIZE_W-1:0];
        CFG_SCR_H: scr_h_r <= cfg_wdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // advance the pipeline unless a finished beat is blocked
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  vrp_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_tvalid),
    .vx        (in_tdata[31:0]),
    .vy        (in_tdata[63:32]),
    .vz        (in_tdata[95:64]),
    .cos_z     (cos_z_r),
    .sin_z     (sin_z_r),
    .cos_x     (cos_x_r),
    .sin_x     (sin_x_r),
    .scl_x     (scl_x_r),
    .scl_y     (scl_y_r),
    .out_valid (fr_valid),
    .out_data  (fr_data)
  );

  vrp_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (fr_valid),
    .in_data   (fr_data),
    .out_valid (dv_valid),
    .out_data  (dv_data)
  );

  vrp_screen #(.FRAC_BITS(FRAC_BITS)) u_screen (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_valid   (dv_valid),
    .in_data    (dv_data),
    .scr_w      (scr_w_r),
    .scr_h      (scr_h_r),
    .out_valid  (out_tvalid),
    .screen_x   (screen_x),
    .screen_y   (screen_y),
    .depth_zero (depth_zero)
  );

  assign out_tdata = {screen_y, screen_x};
  assign out_tuser = depth_zero;

endmodule

/* hw/rtl/vrp_front.sv */
// Rotation about Z and X, projection scaling, depth offset and divider prep.
module vrp_front #(
  parameter int FRAC_BITS = vrp_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [31:0]          vx,
  input  logic [31:0]          vy,
  input  logic [31:0]          vz,
  input  logic [15:0]          cos_z,
  input  logic [15:0]          sin_z,
  input  logic [15:0]          cos_x,
  input  logic [15:0]          sin_x,
  input  logic [15:0]          scl_x,
  input  logic [15:0]          scl_y,
  output logic                 out_valid,
  output vrp_pkg::div_in_t     out_data
);
  import vrp_pkg::*;

  localparam int          NSTG   = 7;
  localparam logic [48:0] ARND   = 49'(1) << (ANGLE_BITS - 1);
  localparam logic [48:0] SRND   = 49'(1) << (SCALE_BITS - 1);
  localparam logic [31:0] ZD_OFS = 32'(3) << FRAC_BITS;

  logic [NSTG-1:0] vld_r;

  // stage 1: first rotation products
  logic signed [47:0] m_xcz_r, m_ysz_r, m_xsz_r, m_ycz_r;
  logic [31:0]        z_s1_r;
  // stage 2: x', y'
  logic [31:0]        x1_r, y1_r, z_s2_r;
  // stage 3: second rotation products and x scaling product
  logic signed [47:0] m_ycx_r, m_zsx_r, m_ysx_r, m_zcx_r;
  logic signed [48:0] m_px_r;
  // stage 4: y'', z'', scaled x
  logic [31:0]        y2_r, z2_r, px_s4_r;
  // stage 5: y scaling product and offset depth
  logic signed [48:0] m_py_r;
  logic [31:0]        zd_r, px_s5_r;
  // stage 6: scaled y and zero depth flag
  logic [31:0]        px_s6_r, py_s6_r, zd_s6_r;
  logic               flat_s6_r;
  // stage 7: divider operands
  div_in_t            dv_r;

  logic signed [48:0] sum_x1, sum_y1, sum_y2, sum_z2, rnd_px, rnd_py;

  assign sum_x1 = m_xcz_r - m_ysz_r + $signed(ARND);
  assign sum_y1 = m_xsz_r + m_ycz_r + $signed(ARND);
  assign sum_y2 = m_ycx_r - m_zsx_r + $signed(ARND);
  assign sum_z2 = m_ysx_r + m_zcx_r + $signed(ARND);
  assign rnd_px = m_px_r + $signed(SRND);
  assign rnd_py = m_py_r + $signed(SRND);

  // advance valid bits with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NSTG-2:0], in_valid};
    end
  end

  // datapath stages
  always_ff @(posedge clk) begin
    if (en) begin
      m_xcz_r   <= $signed(vx) * $signed(cos_z);
      m_ysz_r   <= $signed(vy) * $signed(sin_z);
      m_xsz_r   <= $signed(vx) * $signed(sin_z);
      m_ycz_r   <= $signed(vy) * $signed(cos_z);
      z_s1_r    <= vz;

      x1_r      <= sum_x1[ANGLE_BITS+31:ANGLE_BITS];
      y1_r      <= sum_y1[ANGLE_BITS+31:ANGLE_BITS];
      z_s2_r    <= z_s1_r;

      m_ycx_r   <= $signed(y1_r) * $signed(cos_x);
      m_zsx_r   <= $signed(z_s2_r) * $signed(sin_x);
      m_ysx_r   <= $signed(y1_r) * $signed(sin_x);
      m_zcx_r   <= $signed(z_s2_r) * $signed(cos_x);
      m_px_r    <= $signed(x1_r) * $signed({1'b0, scl_x});

      y2_r      <= sum_y2[ANGLE_BITS+31:ANGLE_BITS];
      z2_r      <= sum_z2[ANGLE_BITS+31:ANGLE_BITS];
      px_s4_r   <= rnd_px[SCALE_BITS+31:SCALE_BITS];

      m_py_r    <= $signed(y2_r) * $signed({1'b0, scl_y});
      zd_r      <= z2_r + ZD_OFS;
      px_s5_r   <= px_s4_r;

      px_s6_r   <= px_s5_r;
      py_s6_r   <= rnd_py[SCALE_BITS+31:SCALE_BITS];
      zd_s6_r   <= zd_r;
      flat_s6_r <= (zd_r == 32'd0);

      dv_r.mag_x <= px_s6_r[31] ? (32'd0 - px_s6_r) : px_s6_r;
      dv_r.mag_y <= py_s6_r[31] ? (32'd0 - py_s6_r) : py_s6_r;
      dv_r.dmag  <= zd_s6_r[31] ? (32'd0 - zd_s6_r) : zd_s6_r;
      dv_r.neg_x <= px_s6_r[31] ^ zd_s6_r[31];
      dv_r.neg_y <= py_s6_r[31] ^ zd_s6_r[31];
      dv_r.raw_x <= px_s6_r;
      dv_r.raw_y <= py_s6_r;
      dv_r.flat  <= flat_s6_r;
    end
  end

  assign out_valid = vld_r[NSTG-1];
  assign out_data  = dv_r;

endmodule

/* hw/rtl/vrp_div.sv */
// Pipelined restoring divider, two lanes sharing one divisor, one bit per stage.
module vrp_div #(
  parameter int FRAC_BITS = vrp_pkg::FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  vrp_pkg::div_in_t  in_data,
  output logic              out_valid,
  output vrp_pkg::div_out_t out_data
);
  import vrp_pkg::*;

  localparam int NUM_W = 32 + FRAC_BITS;

  logic [NUM_W-1:0] vld_r;
  logic [31:0]      rem_x_r [NUM_W];
  logic [31:0]      rem_y_r [NUM_W];
  logic [NUM_W-1:0] num_x_r [NUM_W];
  logic [NUM_W-1:0] num_y_r [NUM_W];
  logic [31:0]      q_x_r   [NUM_W];
  logic [31:0]      q_y_r   [NUM_W];
  div_meta_t        meta_r  [NUM_W];

  // advance valid bits with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NUM_W-2:0], in_valid};
    end
  end

  for (genvar s = 0; s < NUM_W; s++) begin : g_stage
    logic [31:0]      src_rem_x, src_rem_y, src_q_x, src_q_y;
    logic [NUM_W-1:0] src_num_x, src_num_y;
    div_meta_t        src_meta;
    logic [32:0]      stp_x, stp_y;

    if (s == 0) begin : g_first
      assign src_rem_x = '0;
      assign src_rem_y = '0;
      assign src_q_x   = '0;
      assign src_q_y   = '0;
      assign src_num_x = {in_data.mag_x, {FRAC_BITS{1'b0}}};
      assign src_num_y = {in_data.mag_y, {FRAC_BITS{1'b0}}};
      assign src_meta.dmag  = in_data.dmag;
      assign src_meta.neg_x = in_data.neg_x;
      assign src_meta.neg_y = in_data.neg_y;
      assign src_meta.raw_x = in_data.raw_x;
      assign src_meta.raw_y = in_data.raw_y;
      assign src_meta.flat  = in_data.flat;
    end else begin : g_next
      assign src_rem_x = rem_x_r[s-1];
      assign src_rem_y = rem_y_r[s-1];
      assign src_q_x   = q_x_r[s-1];
      assign src_q_y   = q_y_r[s-1];
      assign src_num_x = num_x_r[s-1];
      assign src_num_y = num_y_r[s-1];
      assign src_meta  = meta_r[s-1];
    end

    assign stp_x = div_step(src_rem_x, src_num_x[NUM_W-1], src_meta.dmag);
    assign stp_y = div_step(src_rem_y, src_num_y[NUM_W-1], src_meta.dmag);

    // retire one quotient bit per lane; keep the low 32 quotient bits
    always_ff @(posedge clk) begin
      if (en) begin
        rem_x_r[s] <= stp_x[31:0];
        rem_y_r[s] <= stp_y[31:0];
        q_x_r[s]   <= {src_q_x[30:0], stp_x[32]};
        q_y_r[s]   <= {src_q_y[30:0], stp_y[32]};
        num_x_r[s] <= src_num_x << 1;
        num_y_r[s] <= src_num_y << 1;
        meta_r[s]  <= src_meta;
      end
    end
  end

  assign out_valid      = vld_r[NUM_W-1];
  assign out_data.q_x   = q_x_r[NUM_W-1];
  assign out_data.q_y   = q_y_r[NUM_W-1];
  assign out_data.neg_x = meta_r[NUM_W-1].neg_x;
  assign out_data.neg_y = meta_r[NUM_W-1].neg_y;
  assign out_data.raw_x = meta_r[NUM_W-1].raw_x;
  assign out_data.raw_y = meta_r[NUM_W-1].raw_y;
  assign out_data.flat  = meta_r[NUM_W-1].flat;

endmodule

/* hw/rtl/vrp_screen.sv */
// Quotient sign fix-up and mapping to screen pixels, ending in the output register.
module vrp_screen #(
  parameter int FRAC_BITS = vrp_pkg::FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_valid,
  input  vrp_pkg::div_out_t          in_data,
  input  logic [vrp_pkg::SIZE_W-1:0] scr_w,
  input  logic [vrp_pkg::SIZE_W-1:0] scr_h,
  output logic                       out_valid,
  output logic [31:0]                screen_x,
  output logic [31:0]                screen_y,
  output logic                       depth_zero
);
  import vrp_pkg::*;

  localparam int          NSTG   = 4;
  localparam logic [31:0] FX_ONE = 32'(1) << FRAC_BITS;

  logic [NSTG-1:0]             vld_r;
  logic [31:0]                 vx_r, vy_r, tx_r, ty_r;
  logic signed [SIZE_W+32:0]   px_r, py_r;
  logic [31:0]                 sx_r, sy_r;
  logic [NSTG-1:0]             flat_r;
  logic signed [SIZE_W+32:0]   rx, ry;

  assign rx = px_r + 1;
  assign ry = py_r + 1;

  // advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NSTG-2:0], in_valid};
    end
  end

  // select, offset, scale by size, halve with rounding
  always_ff @(posedge clk) begin
    if (en) begin
      vx_r   <= in_data.flat ? in_data.raw_x :
                (in_data.neg_x ? (32'd0 - in_data.q_x) : in_data.q_x);
      vy_r   <= in_data.flat ? in_data.raw_y :
                (in_data.neg_y ? (32'd0 - in_data.q_y) : in_data.q_y);
      tx_r   <= vx_r + FX_ONE;
      ty_r   <= vy_r + FX_ONE;
      px_r   <= $signed(tx_r) * $signed({1'b0, scr_w});
      py_r   <= $signed(ty_r) * $signed({1'b0, scr_h});
      sx_r   <= rx[32:1];
      sy_r   <= ry[32:1];
      flat_r <= {flat_r[NSTG-2:0], in_data.flat};
    end
  end

  assign out_valid  = vld_r[NSTG-1];
  assign screen_x   = sx_r;
  assign screen_y   = sy_r;
  assign depth_zero = flat_r[NSTG-1];

endmodule
